/* hw/rtl/dnle_pkg.sv */
// ----------------------------------------------------------------------------
// dnle_pkg - shared definitions for the DNS name label encoder
// Widths, character codes and the per-cell control bundle.
// ----------------------------------------------------------------------------
package dnle_pkg;

    // Character and label-length widths fixed by the wire format
    localparam int CHAR_W        = 8;
    localparam int LEN_W         = 6;
    localparam int MAX_LABEL_DEF = 63;

    // Separator character
    localparam logic [CHAR_W-1:0] DOT_CHAR  = 8'h2E;
    // Root label / name terminator byte
    localparam logic [CHAR_W-1:0] ZERO_BYTE = 8'h00;

    // Control handed from the sequencer to each cell of the label chain
    typedef struct packed {
        logic load;   // capture the incoming character
        logic shift;  // take the right-hand neighbor's character
    } cell_ctrl_t;

endpackage

/* hw/rtl/dnle_cell.sv */
// ----------------------------------------------------------------------------
// dnle_cell - one character slot of the label chain
// Holds one buffered character; loads a new one or takes its neighbor's.
// ----------------------------------------------------------------------------
module dnle_cell (
    input  logic                       aclk,
    input  dnle_pkg::cell_ctrl_t       ctrl,
    input  logic [dnle_pkg::CHAR_W-1:0] char_in,
    input  logic [dnle_pkg::CHAR_W-1:0] neighbor_in,
    output logic [dnle_pkg::CHAR_W-1:0] char_out
);

    logic [dnle_pkg::CHAR_W-1:0] char_reg;

    // Payload only, no reset needed
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            char_reg <= char_in;
        end else if (ctrl.shift) begin
            char_reg <= neighbor_in;
        end
    end

    assign char_out = char_reg;

endmodule

/* hw/rtl/dns_name_label_encoder_core.sv */
// ----------------------------------------------------------------------------
// dns_name_label_encoder_core - dotted name to DNS wire-format encoder
// Buffers label characters in a chain of cells and emits length-prefixed
// labels followed by a terminating zero byte.
// ----------------------------------------------------------------------------
// Characters are taken one per cycle into a row of MAX_LABEL cells, each
// landing in the slot that matches the current label length. A dot, the
// terminator (s_tlast) or a full label drains the chain: the length byte goes
// out, then the characters shift one cell toward the head each cycle, one
// output transaction per cycle while m_tready is high. A terminator then
// sends the zero byte. Input is held off (s_tready low) while a label
// drains and while the zero byte goes out.
// Empty labels emit nothing; characters beyond MAX_LABEL are dropped and
// reported in m_tuser on the terminating byte.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_core #(
    parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Input channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,   // end_of_name
    // Result channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // name_end
    output logic       m_tuser    // [0] label_error
);

    localparam int LEN_W = dnle_pkg::LEN_W;
    localparam int CW    = dnle_pkg::CHAR_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LABEL);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEN,
        ST_DATA,
        ST_TERM
    } state_t;

    state_t           state_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] cnt_reg;
    logic             closed_reg;
    logic             overflow_reg;
    logic             term_pend_reg;
    logic             m_valid_reg;
    logic [CW-1:0]    m_data_reg;
    logic             m_last_reg;
    logic             m_user_reg;

    logic             s_accept;
    logic             is_dot;
    logic             put_char;
    logic             emit;
    logic             drain;
    logic [LEN_W-1:0] len_inc;

    logic [CW-1:0]    cell_data [MAX_LABEL];

    // Input decode
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign is_dot   = (s_tdata == dnle_pkg::DOT_CHAR);
    assign put_char = s_accept && !s_tlast && !is_dot && !closed_reg;
    assign len_inc  = len_reg + LEN_W'(1);

    // Output slot free and a byte to send
    assign emit  = (state_reg != ST_IDLE) && (!m_valid_reg || m_tready);
    assign drain = emit && (state_reg == ST_DATA);

    // Label chain: cell i loads at label length i, shifts toward cell 0
    for (genvar i = 0; i < MAX_LABEL; i++) begin : g_cell
        dnle_pkg::cell_ctrl_t ctrl;
        logic [CW-1:0]        neighbor;

        assign ctrl.load  = put_char && (len_reg == LEN_W'(i));
        assign ctrl.shift = drain;

        if (i == MAX_LABEL - 1) begin : g_tail
            assign neighbor = cell_data[i];
        end else begin : g_body
            assign neighbor = cell_data[i+1];
        end

        dnle_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .char_in     (s_tdata),
            .neighbor_in (neighbor),
            .char_out    (cell_data[i])
        );
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            cnt_reg       <= '0;
            closed_reg    <= 1'b0;
            overflow_reg  <= 1'b0;
            term_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            m_last_reg    <= 1'b0;
            m_user_reg    <= 1'b0;
        end else begin
            // Slot empties on a taken transaction unless refilled below
            if (m_tready && !emit) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (s_tlast) begin
                            closed_reg    <= 1'b0;
                            term_pend_reg <= 1'b1;
                            state_reg     <= (len_reg != '0) ? ST_LEN : ST_TERM;
                        end else if (is_dot) begin
                            closed_reg    <= 1'b0;
                            term_pend_reg <= 1'b0;
                            if (len_reg != '0) begin
                                state_reg <= ST_LEN;
                            end
                        end else if (closed_reg) begin
                            overflow_reg <= 1'b1;
                        end else begin
                            len_reg <= len_inc;
                            if (len_inc >= MAX_LEN) begin
                                closed_reg    <= 1'b1;
                                term_pend_reg <= 1'b0;
                                state_reg     <= ST_LEN;
                            end
                        end
                    end
                end
                ST_LEN: begin
                    if (emit) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= CW'(len_reg);
                        m_last_reg  <= 1'b0;
                        m_user_reg  <= 1'b0;
                        cnt_reg     <= len_reg;
                        len_reg     <= '0;
                        state_reg   <= ST_DATA;
                    end
                end
                ST_DATA: begin
                    if (emit) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= cell_data[0];
                        m_last_reg  <= 1'b0;
                        m_user_reg  <= 1'b0;
                        cnt_reg     <= cnt_reg - LEN_W'(1);
                        if (cnt_reg == LEN_W'(1)) begin
                            state_reg <= term_pend_reg ? ST_TERM : ST_IDLE;
                        end
                    end
                end
                ST_TERM: begin
                    if (emit) begin
                        m_valid_reg   <= 1'b1;
                        m_data_reg    <= dnle_pkg::ZERO_BYTE;
                        m_last_reg    <= 1'b1;
                        m_user_reg    <= overflow_reg;
                        overflow_reg  <= 1'b0;
                        term_pend_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    // Pending label never exceeds the chain length
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= MAX_LEN)
        else $error("label length beyond chain");

    // Draining with nothing left to send
    a_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DATA) |-> (cnt_reg != '0))
        else $error("data state with empty count");

    // A label that reaches the limit is flushed right away
    a_full_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (put_char && (len_inc >= MAX_LEN)) |=> (state_reg == ST_LEN))
        else $error("full label not flushed");

    // Error flag only rides on the terminating byte
    a_err_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("label error outside name end");

endmodule
